[hdl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Operation and status codes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    typedef logic [2:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_ADD = 3'd0;
    localparam t_op OP_SUB = 3'd1;
    localparam t_op OP_MUL = 3'd2;
    localparam t_op OP_DIV = 3'd3;
    localparam t_op OP_LT  = 3'd4;
    localparam t_op OP_GT  = 3'd5;
    localparam t_op OP_EQ  = 3'd6;
    localparam t_op OP_NOP = 3'd7;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_DIV0 = 2'd1;
    localparam t_status ST_OVF  = 2'd2;

endpackage

[hdl/rau_div.sv]
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);
    localparam int CW = $clog2(WIDTH);

    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;

    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[WIDTH]) begin
                r_rem <= w_diff[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add/sub/mul/div and compare of two fractions, reduced by binary GCD.
// ----------------------------------------------------------------------------
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------------
//  input   | i_valid | o_ready | i_op, i_a_num, i_a_den, i_b_num, i_b_den
//  output  | o_valid | i_ready | o_res_num, o_res_den, o_compare_true,
//          |         |         | o_status
//
//  One item at a time; o_ready is high only in the idle state.
//  No-op, zero denominator and divide by zero go from idle straight to the
//  final state; compares pass the multiply states and the combine step;
//  arithmetic adds binary GCD steps, two divisions (skipped for a zero
//  result) and an overflow check. The one shared multiplier forms three
//  products; the divider runs one bit a cycle over 2*VALUE_WIDTH bits, twice.
//  Reset is synchronous, active low, clears the sequencer and output valid.
//  A held result does not block accepting the next item; that item waits in S_FIN until the held result is taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rau_pkg::t_op       i_op,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic               o_compare_true,
    output rau_pkg::t_status   o_status
);
    import rau_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int P  = 2 * VALUE_WIDTH;
    localparam int KW = $clog2(P + 1);
    localparam logic [P-1:0] LIM = (P'(1) << (W - 1)) - P'(1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_COMB  = 4'd4;
    localparam logic [3:0] S_GCD   = 4'd5;
    localparam logic [3:0] S_DIVN  = 4'd6;
    localparam logic [3:0] S_DIVD  = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]   r_state;
    logic [3:0]   n_state;
    t_op          r_op;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic         r_as, r_bs;
    logic [P-1:0] r_p1, r_p2, r_p3;
    logic [P-1:0] r_rn, r_rd, r_gu, r_gv, r_g;
    logic [KW-1:0] r_k;
    logic         r_rs;
    logic         r_cmp;
    t_status      r_st;
    logic         r_ov;

    // operand magnitudes and signs (sign lives on the numerator)
    logic [W-1:0] w_an, w_ad, w_bn, w_bd;
    logic         w_n1, w_n2, w_n3, w_n4;

    assign w_n1 = i_a_num[W-1];
    assign w_n2 = i_a_den[W-1];
    assign w_n3 = i_b_num[W-1];
    assign w_n4 = i_b_den[W-1];
    assign w_an = w_n1 ? (W'(0) - i_a_num[W-1:0]) : i_a_num[W-1:0];
    assign w_ad = w_n2 ? (W'(0) - i_a_den[W-1:0]) : i_a_den[W-1:0];
    assign w_bn = w_n3 ? (W'(0) - i_b_num[W-1:0]) : i_b_num[W-1:0];
    assign w_bd = w_n4 ? (W'(0) - i_b_den[W-1:0]) : i_b_den[W-1:0];

    // shared multiplier
    logic [W-1:0] w_ma, w_mb;
    logic [P-1:0] w_prod;

    always_comb begin
        case (r_state)
            S_MUL0: begin
                w_ma = r_an;
                w_mb = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            S_MUL1: begin
                w_ma = r_bn;
                w_mb = r_ad;
            end
            default: begin
                w_ma = r_ad;
                w_mb = (r_op == OP_DIV) ? r_bn : r_bd;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // combine step: signed sum/difference or plain products, and compares
    logic         w_s2;
    logic [P-1:0] w_rn;
    logic         w_rs;
    logic         w_na, w_nb, w_lt, w_eq, w_cres;

    always_comb begin
        w_s2 = (r_op == OP_SUB) ? !r_bs : r_bs;
        if (r_op == OP_ADD || r_op == OP_SUB) begin
            if (r_as == w_s2) begin
                w_rn = r_p1 + r_p2;
                w_rs = r_as;
            end else if (r_p1 >= r_p2) begin
                w_rn = r_p1 - r_p2;
                w_rs = r_as;
            end else begin
                w_rn = r_p2 - r_p1;
                w_rs = w_s2;
            end
        end else begin
            w_rn = r_p1;
            w_rs = r_as ^ r_bs;
        end
        w_na = r_as && (r_p1 != '0);
        w_nb = r_bs && (r_p2 != '0);
        if (w_na != w_nb) begin
            w_lt = w_na;
            w_eq = 1'b0;
        end else begin
            w_eq = (r_p1 == r_p2);
            w_lt = w_na ? (r_p1 > r_p2) : (r_p1 < r_p2);
        end
        case (r_op)
            OP_LT:   w_cres = w_lt;
            OP_GT:   w_cres = !w_lt && !w_eq;
            default: w_cres = w_eq;
        endcase
    end

    // divider, used for numerator then denominator
    logic         w_gdone;
    logic         w_div_start;
    logic [P-1:0] w_dividend, w_divisor;
    logic         w_div_done;
    logic [P-1:0] w_quot;

    assign w_gdone     = (r_state == S_GCD) && (r_gu == r_gv);
    assign w_div_start = w_gdone || ((r_state == S_DIVN) && w_div_done);
    assign w_dividend  = (r_state == S_GCD) ? r_rn : r_rd;
    assign w_divisor   = (r_state == S_GCD) ? (r_gu << r_k) : r_g;

    rau_div #(.WIDTH(P)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    logic w_in_acc;
    logic w_fin_go;
    assign w_in_acc = i_valid && o_ready;
    assign w_fin_go = (r_state == S_FIN) && (!r_ov || i_ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_op == OP_NOP || w_ad == '0 || w_bd == '0 ||
                        (i_op == OP_DIV && w_bn == '0)) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MUL0;
                    end
                end
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_COMB;
            S_COMB: begin
                if (r_op == OP_LT || r_op == OP_GT || r_op == OP_EQ) begin
                    n_state = S_FIN;
                end else if (w_rn == '0) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD:   if (w_gdone) n_state = S_DIVN;
            S_DIVN:  if (w_div_done) n_state = S_DIVD;
            S_DIVD:  if (w_div_done) n_state = S_CHECK;
            S_CHECK: n_state = S_FIN;
            S_FIN:   if (w_fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op  <= i_op;
                r_an  <= w_an;
                r_ad  <= w_ad;
                r_bn  <= w_bn;
                r_bd  <= w_bd;
                r_as  <= (w_n1 != w_n2) && (w_an != '0);
                r_bs  <= (w_n3 != w_n4) && (w_bn != '0);
                r_rn  <= '0;
                r_rd  <= P'(1);
                r_rs  <= 1'b0;
                r_cmp <= 1'b0;
                if (i_op == OP_NOP) begin
                    r_st <= ST_OK;
                end else if (w_ad == '0 || w_bd == '0 ||
                             (i_op == OP_DIV && w_bn == '0)) begin
                    r_st <= ST_DIV0;
                end else begin
                    r_st <= ST_OK;
                end
            end
            S_MUL0: r_p1 <= w_prod;
            S_MUL1: r_p2 <= w_prod;
            S_MUL2: r_p3 <= w_prod;
            S_COMB: begin
                if (r_op == OP_LT || r_op == OP_GT || r_op == OP_EQ) begin
                    r_cmp <= w_cres;
                end else if (w_rn == '0) begin
                    r_rn <= '0;
                    r_rd <= P'(1);
                    r_rs <= 1'b0;
                end else begin
                    r_rn <= w_rn;
                    r_rd <= r_p3;
                    r_rs <= w_rs;
                    r_gu <= w_rn;
                    r_gv <= r_p3;
                    r_k  <= '0;
                end
            end
            S_GCD: begin
                if (w_gdone) begin
                    r_g <= r_gu << r_k;
                end else if (!r_gu[0] && !r_gv[0]) begin
                    r_gu <= r_gu >> 1;
                    r_gv <= r_gv >> 1;
                    r_k  <= r_k + 1'b1;
                end else if (!r_gu[0]) begin
                    r_gu <= r_gu >> 1;
                end else if (!r_gv[0]) begin
                    r_gv <= r_gv >> 1;
                end else if (r_gu > r_gv) begin
                    r_gu <= r_gu - r_gv;
                end else begin
                    r_gv <= r_gv - r_gu;
                end
            end
            S_DIVN: if (w_div_done) r_rn <= w_quot;
            S_DIVD: if (w_div_done) r_rd <= w_quot;
            S_CHECK: begin
                if (r_rd > LIM || (r_rs ? (r_rn > LIM + P'(1)) : (r_rn > LIM))) begin
                    r_rn <= '0;
                    r_rd <= P'(1);
                    r_rs <= 1'b0;
                    r_st <= ST_OVF;
                end
            end
            default: ;
        endcase
    end

    // output register
    logic [W-1:0] w_num;
    assign w_num = r_rs ? (W'(0) - r_rn[W-1:0]) : r_rn[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fin_go) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            o_res_num      <= 32'($signed(w_num));
            o_res_den      <= 31'(r_rd[W-2:0]);
            o_compare_true <= r_cmp;
            o_status       <= r_st;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;

endmodule

[hdl/rau_checker.sv]
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_res_num,
    input logic [30:0]        o_res_den,
    input logic               o_compare_true,
    input rau_pkg::t_status   o_status
);
    import rau_pkg::*;

    // one item in flight: no accept right after an accept
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted a second item back to back");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DIV0 || o_status == ST_OVF)
        |-> o_res_num == 0 && o_res_den == 31'd1 && !o_compare_true)
        else $error("error result not 0/1");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res_num == 0 |-> o_res_den == 31'd1)
        else $error("zero not reduced to 0/1");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res_den != 31'd0)
        else $error("zero denominator on output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_num) && $stable(o_res_den))
        else $error("stalled result changed");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_res_num      (o_res_num),
    .o_res_den      (o_res_den),
    .o_compare_true (o_compare_true),
    .o_status       (o_status)
);

[tb/rational_arithmetic_unit_test.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Self-checking bench for the rational arithmetic unit: directed corner items,
// then random fractions under three idle patterns and one long output stall.
// Every result is checked field by field against an in-bench fraction model.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int WDOG_LIMIT  = 5000;  // idle cycles allowed with no handshake
    localparam int DRAIN_WAIT  = 400;
    localparam int RANDOM_ITEMS = 175;  // per idle phase

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               cmp;
        t_status            st;
    } t_fraction_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    t_op                i_op;
    logic signed [31:0] i_a_num;
    logic signed [31:0] i_a_den;
    logic signed [31:0] i_b_num;
    logic signed [31:0] i_b_den;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_res_num;
    logic [30:0]        o_res_den;
    logic               o_compare_true;
    t_status            o_status;

    t_fraction_result   pending_results[$];
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 recv_hold_cycles;
    int                 fail_count;
    int                 items_sent;
    int                 results_checked;
    int                 op_seen[8];
    int                 status_seen[4];
    int                 idle_cycles;

    rational_arithmetic_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_a_num        (i_a_num),
        .i_a_den        (i_a_den),
        .i_b_num        (i_b_num),
        .i_b_den        (i_b_den),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_res_num      (o_res_num),
        .o_res_den      (o_res_den),
        .o_compare_true (o_compare_true),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // magnitude of a 32-bit two's complement value, sign returned separately
    function automatic logic [63:0] magnitude(input logic [31:0] raw, output logic neg);
        logic [31:0] m;
        neg = raw[31];
        m   = neg ? (32'd0 - raw) : raw;
        return {32'd0, m};
    endfunction

    function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        if (x < y) begin
            t = x;
            x = y;
            y = t;
        end
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // exact fraction arithmetic / comparison, reduced to lowest terms
    function automatic t_fraction_result reduce_fraction_op(input t_op op,
            input logic [31:0] a_n, input logic [31:0] a_d,
            input logic [31:0] b_n, input logic [31:0] b_d);
        t_fraction_result r;
        logic n1, n2, n3, n4, as, bs, rs, s1, s2, na, nb, lt, eq, hit;
        logic [63:0] an, ad, bn, bd, rn, rd, m1, m2, g, lim;
        an = magnitude(a_n, n1);
        ad = magnitude(a_d, n2);
        bn = magnitude(b_n, n3);
        bd = magnitude(b_d, n4);
        as = (n1 != n2) && an != 0;
        bs = (n3 != n4) && bn != 0;
        r  = '{num: 32'sd0, den: 31'd1, cmp: 1'b0, st: ST_OK};
        if (op == OP_NOP) return r;
        if (ad == 0 || bd == 0) begin
            r.st = ST_DIV0;
            return r;
        end
        if (op == OP_LT || op == OP_GT || op == OP_EQ) begin
            m1 = an * bd;
            m2 = bn * ad;
            na = as && m1 != 0;
            nb = bs && m2 != 0;
            if (na != nb) begin
                lt = na;
                eq = 1'b0;
            end else begin
                eq = (m1 == m2);
                lt = na ? (m1 > m2) : (m1 < m2);
            end
            hit   = (op == OP_LT) ? lt : (op == OP_GT) ? (!lt && !eq) : eq;
            r.cmp = hit;
            return r;
        end
        if (op == OP_ADD || op == OP_SUB) begin
            m1 = an * bd;
            m2 = bn * ad;
            s1 = as;
            s2 = (op == OP_SUB) ? !bs : bs;
            if (s1 == s2) begin
                rn = m1 + m2;
                rs = s1;
            end else if (m1 >= m2) begin
                rn = m1 - m2;
                rs = s1;
            end else begin
                rn = m2 - m1;
                rs = s2;
            end
            rd = ad * bd;
        end else if (op == OP_MUL) begin
            rn = an * bn;
            rd = ad * bd;
            rs = as != bs;
        end else begin
            if (bn == 0) begin
                r.st = ST_DIV0;
                return r;
            end
            rn = an * bd;
            rd = ad * bn;
            rs = as != bs;
        end
        g = euclid_gcd(rn, rd);
        if (g != 0) begin
            rn = rn / g;
            rd = rd / g;
        end
        if (rn == 0) begin
            rd = 1;
            rs = 1'b0;
        end
        lim = 64'h7FFF_FFFF;
        if (rd > lim || (rs ? rn > lim + 1 : rn > lim)) begin
            r.st = ST_OVF;
            return r;
        end
        r.num = rs ? (32'd0 - rn[31:0]) : rn[31:0];
        r.den = rd[30:0];
        return r;
    endfunction

    // offer one item; returns at the edge where it was taken
    task automatic send_item(input t_op op, input logic [31:0] a_n, input logic [31:0] a_d,
            input logic [31:0] b_n, input logic [31:0] b_d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_a_num <= a_n;
        i_a_den <= a_d;
        i_b_num <= b_n;
        i_b_den <= b_d;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(reduce_fraction_op(op, a_n, a_d, b_n, b_d));
        items_sent++;
        op_seen[op]++;
    endtask

    // stop offering and wait until every accepted item has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // field value: extremes, small values, or fully random bits
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'(int'($urandom_range(2)) - 1);
            3, 4, 5: return 32'(int'($urandom_range(40)) - 20);
            6:       return 32'(int'($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_den();
        logic [31:0] v;
        v = pick_value();
        if (v == 0 && $urandom_range(3) != 0) v = 32'd1;
        return v;
    endfunction

    task automatic send_random_items(input int count);
        t_op op;
        repeat (count) begin
            op = ($urandom_range(19) == 0) ? OP_NOP : t_op'($urandom_range(6));
            send_item(op, pick_value(), pick_den(), pick_value(), pick_den());
        end
    endtask

    task automatic test_directed();
        t_op op;
        send_idle_pct = 0;
        // every operation on simple values
        for (int k = 0; k <= 7; k++) begin
            op = t_op'(k);
            send_item(op, 32'sd3, 32'sd4, -32'sd5, 32'sd6);
        end
        // extreme numerators and denominators
        send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(OP_MUL, 32'h8000_0000, 32'sd1, -32'sd1, 32'sd1);    // overflow
        send_item(OP_SUB, 32'h8000_0000, 32'sd1, 32'sd0, 32'sd1);     // min stays
        send_item(OP_MUL, 32'h7FFF_FFFF, 32'sd1, 32'h7FFF_FFFF, 32'sd1);
        send_item(OP_DIV, 32'sd1, 32'h7FFF_FFFF, 32'sd1, 32'h8000_0000);
        // zero result reduces to 0/1
        send_item(OP_SUB, 32'sd7, -32'sd3, -32'sd14, 32'sd6);
        // division by a zero fraction, zero denominator in either operand
        send_item(OP_DIV, 32'sd5, 32'sd2, 32'sd0, -32'sd9);
        send_item(OP_ADD, 32'sd5, 32'sd0, 32'sd1, 32'sd1);
        send_item(OP_EQ,  32'sd5, 32'sd1, 32'sd1, 32'sd0);
        // compares: negatives, equal values in different forms, signed zeros
        send_item(OP_LT, -32'sd1, 32'sd2, 32'sd1, -32'sd3);
        send_item(OP_GT, -32'sd1, 32'sd2, 32'sd1, -32'sd3);
        send_item(OP_EQ, 32'sd2, -32'sd4, -32'sd3, 32'sd6);
        send_item(OP_EQ, 32'sd0, -32'sd4, 32'sd0, 32'sd6);
        send_item(OP_LT, 32'h8000_0000, 32'sd1, 32'h7FFF_FFFF, 32'sd1);
        send_item(OP_GT, 32'sd0, 32'sd1, -32'sd1, 32'sd1);
        send_item(OP_NOP, 32'h8000_0000, 32'sd0, 32'h7FFF_FFFF, 32'sd0);
        wait_drained();
    endtask

    task automatic test_random(input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        send_random_items(RANDOM_ITEMS);
        wait_drained();
    endtask

    // receiver stops for a long stretch while items keep coming
    task automatic test_backpressure();
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        recv_hold_cycles = 800;
        send_random_items(8);
        wait_drained();
    endtask

    // result checker and receiver ready generation
    always @(posedge i_clk) begin
        t_fraction_result exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    $error("result with no item outstanding");
                    fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    status_seen[o_status]++;
                    if (o_res_num !== exp_r.num) begin
                        $error("res_num expected %0d actual %0d", exp_r.num, o_res_num);
                        fail_count++;
                    end
                    if (o_res_den !== exp_r.den) begin
                        $error("res_den expected %0d actual %0d", exp_r.den, o_res_den);
                        fail_count++;
                    end
                    if (o_compare_true !== exp_r.cmp) begin
                        $error("compare_true expected %0d actual %0d",
                               exp_r.cmp, o_compare_true);
                        fail_count++;
                    end
                    if (o_status !== exp_r.st) begin
                        $error("status expected %0d actual %0d", exp_r.st, o_status);
                        fail_count++;
                    end
                end
            end
            if (recv_hold_cycles > 0) begin
                recv_hold_cycles <= recv_hold_cycles - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_op             = OP_NOP;
        i_a_num          = '0;
        i_a_den          = 32'sd1;
        i_b_num          = '0;
        i_b_den          = 32'sd1;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        recv_hold_cycles = 0;
        fail_count       = 0;
        items_sent       = 0;
        results_checked  = 0;
        idle_cycles      = 0;
        foreach (op_seen[k]) op_seen[k] = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(32, 78);
        test_random(78, 32);
        test_random(0, 0);
        test_backpressure();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d items, %0d results; ops add..nop: %0d %0d %0d %0d %0d %0d %0d %0d",
                 items_sent, results_checked, op_seen[0], op_seen[1], op_seen[2],
                 op_seen[3], op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
        $display("Status ok/div0/ovf: %0d/%0d/%0d, one long output stall included",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
